// ===== rtl/run_length_byte_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// run length byte decoder assertion macros
// shared assertion forms for the decoder top level
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_BYTE_DECODER_DEFINES_SVH
`define RUN_LENGTH_BYTE_DECODER_DEFINES_SVH

// property checked on every clock edge outside reset
`define RLBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define RLBD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/rlbd_pkg.sv =====
// ----------------------------------------------------------------------------
// run length byte decoder package
// transfer types, command codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package rlbd_pkg;

  localparam logic [7:0] LowMask = 8'h3F;
  localparam logic [7:0] CmdMask = 8'hC0;

  typedef enum logic [1:0] {
    CMD_SET   = 2'b00,
    CMD_LIT   = 2'b01,
    CMD_FILL  = 2'b10,
    CMD_COUNT = 2'b11
  } cmd_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       block_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       block_end;
    logic       format_error;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic hdr_load;
    logic set_target;
    logic op_load;
    logic lit_load;
    logic run_load;
    logic emit_lit;
    logic emit_run;
    logic emit_flag;
    logic flag_err;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic bad_set;
    logic overflow;
    logic hdr_last;
    logic len_zero;
    logic last_byte;
    logic left_one;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/rlbd_datapath.sv =====
// ----------------------------------------------------------------------------
// run length byte decoder datapath
// length and count registers, run values and the output register
// ----------------------------------------------------------------------------
module rlbd_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          stream_byte_i,
  input  rlbd_pkg::dp_cmd_t   cmd_i,
  output rlbd_pkg::dp_sts_t   sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output rlbd_pkg::out_item_t out_item_o
);
  import rlbd_pkg::*;

  logic [23:0] length_q, length_d;
  logic [23:0] written_q, written_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  fill_q, fill_d;
  logic [6:0]  left_q, left_d;
  logic        target_q, target_d;
  logic [1:0]  pos_q, pos_d;
  logic        run_count_q, run_count_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic [5:0]  low;
  logic [1:0]  cmd_bits;
  logic [6:0]  run_len;
  logic [23:0] length_merge;
  logic [24:0] run_end;
  logic [23:0] written_inc;
  logic        emit;

  assign low      = 6'(stream_byte_i & LowMask);
  assign cmd_bits = 2'((stream_byte_i & CmdMask) >> 6);
  assign run_len  = {1'b0, low} + 7'd1;
  assign run_end  = {1'b0, written_q} + {18'd0, run_len};
  assign written_inc = written_q + 24'd1;
  assign emit     = cmd_i.emit_lit | cmd_i.emit_run;

  always_comb begin
    case (pos_q)
      2'd0:    length_merge = length_q | {16'd0, stream_byte_i};
      2'd1:    length_merge = length_q | {8'd0, stream_byte_i, 8'd0};
      2'd2:    length_merge = length_q | {stream_byte_i, 16'd0};
      default: length_merge = length_q;
    endcase
  end

  assign sts_o.cmd       = cmd_e'(cmd_bits);
  assign sts_o.bad_set   = low > 6'd1;
  assign sts_o.overflow  = run_end > {1'b0, length_q};
  assign sts_o.hdr_last  = pos_q == 2'd2;
  assign sts_o.len_zero  = length_merge == 24'd0;
  assign sts_o.last_byte = written_inc == length_q;
  assign sts_o.left_one  = left_q == 7'd1;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    length_d    = length_q;
    written_d   = written_q;
    count_d     = count_q;
    fill_d      = fill_q;
    left_d      = left_q;
    target_d    = target_q;
    pos_d       = pos_q;
    run_count_d = run_count_q;
    if (cmd_i.clear) begin
      length_d  = 24'd0;
      written_d = 24'd0;
      count_d   = 8'd0;
      fill_d    = 8'd0;
      left_d    = 7'd0;
      target_d  = 1'b0;
      pos_d     = 2'd0;
    end
    if (cmd_i.hdr_load) begin
      length_d = length_merge;
      pos_d    = (pos_q == 2'd2) ? 2'd0 : pos_q + 2'd1;
    end
    if (cmd_i.set_target) target_d = low[0];
    if (cmd_i.op_load) begin
      if (target_q) fill_d = stream_byte_i;
      else count_d = stream_byte_i;
    end
    if (cmd_i.lit_load || cmd_i.run_load) left_d = run_len;
    if (cmd_i.run_load) run_count_d = sts_o.cmd == CMD_COUNT;
    if (emit) begin
      written_d = written_inc;
      left_d    = left_q - 7'd1;
    end
    if (cmd_i.emit_run && run_count_q) count_d = count_q + 8'd1;
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d       = 1'b1;
      out_d.out_byte    = cmd_i.emit_lit ? stream_byte_i : (run_count_q ? count_q : fill_q);
      out_d.byte_valid  = 1'b1;
      out_d.block_end   = sts_o.last_byte;
      out_d.format_error = 1'b0;
    end else if (cmd_i.emit_flag) begin
      out_valid_d        = 1'b1;
      out_d.out_byte     = 8'd0;
      out_d.byte_valid   = 1'b0;
      out_d.block_end    = 1'b1;
      out_d.format_error = cmd_i.flag_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q    <= 24'd0;
      written_q   <= 24'd0;
      count_q     <= 8'd0;
      fill_q      <= 8'd0;
      left_q      <= 7'd0;
      target_q    <= 1'b0;
      pos_q       <= 2'd0;
      run_count_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      length_q    <= length_d;
      written_q   <= written_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      left_q      <= left_d;
      target_q    <= target_d;
      pos_q       <= pos_d;
      run_count_q <= run_count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/rlbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// run length byte decoder controller
// decode phase state machine issuing datapath commands
// ----------------------------------------------------------------------------
module rlbd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              block_start_i,
  output logic              in_stall_o,
  input  rlbd_pkg::dp_sts_t sts_i,
  output rlbd_pkg::dp_cmd_t cmd_o
);
  import rlbd_pkg::*;

  typedef enum logic [5:0] {
    ST_STOP    = 6'b000001,
    ST_HEADER  = 6'b000010,
    ST_COMMAND = 6'b000100,
    ST_OPERAND = 6'b001000,
    ST_LITERAL = 6'b010000,
    ST_RUN     = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q == ST_RUN) || !sts_i.out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    if (accept && block_start_i) begin
      cmd_o.clear = 1'b1;
      state_d     = ST_HEADER;
    end else begin
      unique case (state_q)
        ST_STOP: ;
        ST_HEADER: begin
          if (accept) begin
            cmd_o.hdr_load = 1'b1;
            if (sts_i.hdr_last) begin
              if (sts_i.len_zero) begin
                cmd_o.emit_flag = 1'b1;
                state_d         = ST_STOP;
              end else begin
                state_d = ST_COMMAND;
              end
            end
          end
        end
        ST_OPERAND: begin
          if (accept) begin
            cmd_o.op_load = 1'b1;
            state_d       = ST_COMMAND;
          end
        end
        ST_LITERAL: begin
          if (accept) begin
            cmd_o.emit_lit = 1'b1;
            if (sts_i.last_byte) state_d = ST_STOP;
            else if (sts_i.left_one) state_d = ST_COMMAND;
          end
        end
        ST_COMMAND: begin
          if (accept) begin
            if (sts_i.cmd == CMD_SET) begin
              if (sts_i.bad_set) begin
                cmd_o.emit_flag = 1'b1;
                cmd_o.flag_err  = 1'b1;
                state_d         = ST_STOP;
              end else begin
                cmd_o.set_target = 1'b1;
                state_d          = ST_OPERAND;
              end
            end else if (sts_i.overflow) begin
              cmd_o.emit_flag = 1'b1;
              cmd_o.flag_err  = 1'b1;
              state_d         = ST_STOP;
            end else if (sts_i.cmd == CMD_LIT) begin
              cmd_o.lit_load = 1'b1;
              state_d        = ST_LITERAL;
            end else begin
              cmd_o.run_load = 1'b1;
              state_d        = ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (sts_i.out_free) begin
            cmd_o.emit_run = 1'b1;
            if (sts_i.last_byte) state_d = ST_STOP;
            else if (sts_i.left_one) state_d = ST_COMMAND;
          end
        end
        default: state_d = ST_STOP;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STOP;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/run_length_byte_decoder.sv =====
// ----------------------------------------------------------------------------
// run length byte decoder
// expands a compressed byte stream of literal, fill and counting runs
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o carry one stream byte per transfer,
//   with block_start set on header byte 0 of a new block; the next three
//   bytes give the output length, least significant byte first
// output channel: out_valid_o / out_stall_i carry one result per transfer:
//   a decoded byte, or a flag-only result for an empty block or format error
// ordering: a literal byte or a flag result is written into the output register
//   when the byte that causes it is taken; a fill or counting run passes from its
//   command byte through the run state before its first byte is registered
// input pacing: header, operand and literal bytes are taken back to back while
//   the output register is free; a run of n fill or counting bytes is emitted
//   through the single output register, with the input stalled meanwhile
// the output register lets the next byte be taken in the cycle a waiting
//   result is transferred
// reset: the block is stopped and ignores bytes until one with block_start
// receiver stall: the output holds its result and the input stalls until
//   the output register can take a new result; no result is lost
// ----------------------------------------------------------------------------
`include "run_length_byte_decoder_defines.svh"

module run_length_byte_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rlbd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rlbd_pkg::out_item_t out_item_o
);
  import rlbd_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    byte_emit;
  logic    any_emit;
  logic    flag_shown;

  rlbd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .block_start_i (in_item_i.block_start),
    .in_stall_o    (in_stall_o),
    .sts_i         (dp_sts),
    .cmd_o         (dp_cmd)
  );

  rlbd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stream_byte_i (in_item_i.stream_byte),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_item_o    (out_item_o)
  );

  assign byte_emit  = dp_cmd.emit_lit || dp_cmd.emit_run;
  assign any_emit   = byte_emit || dp_cmd.emit_flag;
  assign flag_shown = out_valid_o && out_item_o.block_end && !out_item_o.byte_valid;

  `RLBD_ASSERT(a_emit_needs_slot, any_emit |-> dp_sts.out_free, "result issued while output busy")
  `RLBD_ASSERT(a_flag_shows_end, dp_cmd.emit_flag |=> flag_shown, "flag result not presented")
  `RLBD_ASSERT(a_run_stalls_input, dp_cmd.emit_run |-> in_stall_o, "input taken during a run")
  `RLBD_ASSERT_NEVER(a_emit_and_flag, byte_emit && dp_cmd.emit_flag, "two results in one cycle")

endmodule

// ===== tb/sv/run_length_byte_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// run length byte decoder testbench
// feeds a directed table and then random compressed blocks through the
// decoder, with random idling on both channels, and checks every output
// transfer against a decoder model kept inside the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module run_length_byte_decoder_tb;
  import rlbd_pkg::*;

  localparam int CycleLimit    = 500000;
  localparam int ItemsPerPhase = 62;
  localparam int LongHold      = 400;
  localparam int TailCycles    = 20;

  localparam logic [5:0] SetCount = 6'd0;
  localparam logic [5:0] SetFill  = 6'd1;

  localparam out_item_t NoRes    = '0;
  localparam out_item_t EmptyEnd = '{out_byte: 8'h00, byte_valid: 1'b0,
                                     block_end: 1'b1, format_error: 1'b0};
  localparam out_item_t ErrEnd   = '{out_byte: 8'h00, byte_valid: 1'b0,
                                     block_end: 1'b1, format_error: 1'b1};

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_ONE} row_kind_e;

  typedef struct packed {
    in_item_t  item;
    row_kind_e kind;
    out_item_t typed;
  } stim_t;

  typedef enum logic [2:0] {S_IDLE, S_LEN, S_CMD, S_ARG, S_COPY} dec_state_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  row_kind_e cur_kind  = ROW_PREDICT;
  out_item_t cur_typed = '0;

  stim_t     send_q[$];
  out_item_t decoded_q[$];
  out_item_t scratch_q[$];

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int mismatch_cnt  = 0;
  int cycle_cnt     = 0;

  // decoder model state
  dec_state_e  st        = S_IDLE;
  logic [1:0]  len_idx   = '0;
  logic [23:0] blk_len   = '0;
  logic [23:0] n_out     = '0;
  logic [7:0]  cnt_val   = '0;
  logic [7:0]  fil_val   = '0;
  logic [6:0]  copy_left = '0;
  logic        arg_fill  = 1'b0;

  stim_t dir_tab [28] = '{
    '{'{8'hFF, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'h00, 1'b1}, ROW_NONE,    NoRes},
    '{'{8'h00, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'h00, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'h00, 1'b0}, ROW_ONE,     EmptyEnd},
    '{'{8'hAA, 1'b1}, ROW_NONE,    NoRes},
    '{'{8'hFF, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'hFF, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'hFF, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'h01, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'h77, 1'b0}, ROW_NONE,    NoRes},
    // restart in the middle of a block, fill value goes back to zero
    '{'{8'h00, 1'b1}, ROW_NONE,    NoRes},
    '{'{8'h07, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'h00, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'h00, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'h80, 1'b0}, ROW_PREDICT, NoRes},
    '{'{8'h00, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'hFF, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'hC1, 1'b0}, ROW_PREDICT, NoRes},
    '{'{8'h41, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'h00, 1'b0}, ROW_PREDICT, NoRes},
    '{'{8'hFF, 1'b0}, ROW_PREDICT, NoRes},
    // run longer than what is left of the block
    '{'{8'h82, 1'b0}, ROW_ONE,     ErrEnd},
    '{'{8'h3C, 1'b1}, ROW_NONE,    NoRes},
    '{'{8'h01, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'h00, 1'b0}, ROW_NONE,    NoRes},
    '{'{8'h00, 1'b0}, ROW_NONE,    NoRes},
    // set command with an undefined target
    '{'{8'h3F, 1'b0}, ROW_ONE,     ErrEnd}
  };

  run_length_byte_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    end
  endtask

  task automatic push_byte(logic [7:0] b, ref out_item_t q[$]);
    n_out = n_out + 24'd1;
    q.push_back('{out_byte: b, byte_valid: 1'b1, block_end: n_out == blk_len,
                  format_error: 1'b0});
    if (n_out == blk_len) begin
      st = S_IDLE;
    end
  endtask

  task automatic decode_step(in_item_t it, ref out_item_t q[$]);
    logic [5:0]  low;
    cmd_e        op;
    logic [24:0] need;
    low  = it.stream_byte[5:0];
    op   = cmd_e'(it.stream_byte[7:6]);
    need = 25'(n_out) + 25'(low) + 25'd1;
    if (it.block_start) begin
      st        = S_LEN;
      len_idx   = '0;
      blk_len   = '0;
      n_out     = '0;
      cnt_val   = '0;
      fil_val   = '0;
      copy_left = '0;
      arg_fill  = 1'b0;
    end else begin
      case (st)
        S_LEN: begin
          blk_len = blk_len | (24'(it.stream_byte) << (8 * len_idx));
          len_idx = len_idx + 2'd1;
          if (len_idx == 2'd3) begin
            len_idx = '0;
            if (blk_len == '0) begin
              q.push_back(EmptyEnd);
              st = S_IDLE;
            end else begin
              st = S_CMD;
            end
          end
        end
        S_ARG: begin
          if (arg_fill) begin
            fil_val = it.stream_byte;
          end else begin
            cnt_val = it.stream_byte;
          end
          st = S_CMD;
        end
        S_COPY: begin
          push_byte(it.stream_byte, q);
          copy_left = copy_left - 7'd1;
          if (st == S_COPY && copy_left == '0) begin
            st = S_CMD;
          end
        end
        S_CMD: begin
          if (op == CMD_SET) begin
            if (low == SetCount || low == SetFill) begin
              arg_fill = low[0];
              st       = S_ARG;
            end else begin
              q.push_back(ErrEnd);
              st = S_IDLE;
            end
          end else if (need > 25'(blk_len)) begin
            q.push_back(ErrEnd);
            st = S_IDLE;
          end else if (op == CMD_LIT) begin
            copy_left = 7'(low) + 7'd1;
            st        = S_COPY;
          end else begin
            for (int n = 0; n <= int'(low); n++) begin
              if (op == CMD_FILL) begin
                push_byte(fil_val, q);
              end else begin
                push_byte(cnt_val, q);
                cnt_val = cnt_val + 8'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  function automatic void queue_byte(logic [7:0] b, logic s);
    send_q.push_back('{item: '{stream_byte: b, block_start: s}, kind: ROW_PREDICT,
                       typed: NoRes});
  endfunction

  function automatic cmd_e pick_run();
    case ($urandom_range(2))
      0:       return CMD_LIT;
      1:       return CMD_FILL;
      default: return CMD_COUNT;
    endcase
  endfunction

  // one block: header, then commands until the length is reached, an error
  // is provoked, or the block is abandoned for the next start
  task automatic queue_block(ref int budget);
    logic [23:0] blen;
    logic [5:0]  low;
    cmd_e        op;
    int          done;
    int          left;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      blen = '0;
    end else if (pick < 12) begin
      blen = 24'($urandom_range(200, 65));
    end else if (pick < 16) begin
      blen = 24'($urandom_range(24'hFFFFFF, 256));
    end else begin
      blen = 24'($urandom_range(48, 1));
    end
    queue_byte(8'($urandom), 1'b1);
    queue_byte(blen[7:0], 1'b0);
    queue_byte(blen[15:8], 1'b0);
    queue_byte(blen[23:16], 1'b0);
    budget -= 4;
    done = 0;
    while (blen != '0 && done < int'(blen) && budget > 0) begin
      left = int'(blen) - done;
      pick = $urandom_range(99);
      if (pick < 5) begin
        queue_byte({CMD_SET, 6'($urandom_range(63, 2))}, 1'b0);
        budget--;
        return;
      end else if (pick < 9 && left <= 63) begin
        low = 6'($urandom_range(63, left));
        queue_byte({pick_run(), low}, 1'b0);
        budget--;
        return;
      end else if (pick < 12) begin
        return;
      end else if (pick < 26) begin
        queue_byte({CMD_SET, $urandom_range(1) ? SetFill : SetCount}, 1'b0);
        queue_byte(8'($urandom), 1'b0);
        budget -= 2;
      end else begin
        low = 6'($urandom_range(left > 64 ? 63 : left - 1, 0));
        op  = pick_run();
        queue_byte({op, low}, 1'b0);
        budget--;
        if (op == CMD_LIT) begin
          for (int k = 0; k <= int'(low); k++) begin
            queue_byte(8'($urandom), 1'b0);
            budget--;
          end
        end
        done += int'(low) + 1;
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (send_q.size() != 0 || in_valid_i || decoded_q.size() != 0);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    stim_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      cur_kind   <= ROW_PREDICT;
      cur_typed  <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = send_q.pop_front();
        in_valid_i <= 1'b1;
        in_item_i  <= nxt.item;
        cur_kind   <= nxt.kind;
        cur_typed  <= nxt.typed;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left   <= LongHold;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // transfer monitor and checker
  always @(posedge clk_i) begin : check_p
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (cur_kind == ROW_PREDICT) begin
          decode_step(in_item_i, decoded_q);
        end else begin
          decode_step(in_item_i, scratch_q);
          scratch_q.delete();
          if (cur_kind == ROW_ONE) begin
            decoded_q.push_back(cur_typed);
          end
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_item_o), '0);
        end else begin
          want = decoded_q.pop_front();
          if (out_item_o.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", 32'(out_item_o.out_byte), 32'(want.out_byte));
          end
          if (out_item_o.byte_valid !== want.byte_valid) begin
            report_mismatch("byte_valid", 32'(out_item_o.byte_valid), 32'(want.byte_valid));
          end
          if (out_item_o.block_end !== want.block_end) begin
            report_mismatch("block_end", 32'(out_item_o.block_end), 32'(want.block_end));
          end
          if (out_item_o.format_error !== want.format_error) begin
            report_mismatch("format_error", 32'(out_item_o.format_error),
                            32'(want.format_error));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("run_length_byte_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    int budget;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    tx_idle_pct = 33;
    rx_idle_pct = 46;
    foreach (dir_tab[i]) begin
      send_q.push_back(dir_tab[i]);
    end
    wait_drained();
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 46 : 0;
      rx_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 33 : 0;
      budget = ItemsPerPhase;
      while (budget > 0) begin
        queue_block(budget);
        if ($urandom_range(99) < 20) begin
          repeat ($urandom_range(3, 1)) queue_byte(8'($urandom), 1'b0);
        end
      end
      // receiver holds off at the start of the last phase, so the input backs up
      if (ph == 2) begin
        hold_requests++;
      end
      wait_drained();
    end
    repeat (TailCycles) @(negedge clk_i);
    if (decoded_q.size() != 0) begin
      report_mismatch("results never seen", 32'(decoded_q.size()), '0);
    end
    if (mismatch_cnt == 0) begin
      $display("run_length_byte_decoder regression: pass");
    end else begin
      $display("run_length_byte_decoder regression: fail");
    end
    $finish;
  end

endmodule
